@@ rtl/qte_pkg.sv @@
// Shared types, widths and arithmetic helpers for the quaternion to Euler angle core.
// No dependencies; every other file in rtl/ imports this package.
package qte_pkg;

    localparam int CORDIC_STEPS_DEF = 16;
    localparam int ANGLE_FRAC_DEF   = 13;
    localparam int ACC_FRAC         = 30;

    localparam int QUAT_W     = 16;
    localparam int PROD_W     = 34;
    localparam int ARG_W      = 30;
    localparam int ROOT_W     = 29;
    localparam int SQIN_W     = 2 * ROOT_W;
    localparam int REM_W      = 32;
    localparam int SQRT_STEPS = SQIN_W / 2;
    localparam int VEC_W      = 37;
    localparam int ACC_W      = 35;
    localparam int ROLL_W     = 16;
    localparam int PITCH_W    = 15;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);

    localparam logic signed [ACC_W-1:0]  PI_Q30   = 35'sd3373259426;
    localparam logic signed [PROD_W-1:0] ONE_Q28  = 34'sd268435456;
    localparam logic [SQIN_W-1:0]        ONE_Q56  = SQIN_W'(1) << 56;

    typedef struct packed {
        logic signed [PROD_W-1:0] r_num;
        logic signed [PROD_W-1:0] r_den;
        logic signed [PROD_W-1:0] y_num;
        logic signed [PROD_W-1:0] y_den;
        logic signed [ARG_W-1:0]  p_arg;
        logic [SQIN_W-1:0]        sq_in;
    } t_front_item;

    typedef struct packed {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [ACC_W-1:0] acc;
        logic                    zero;
    } t_lane;

    typedef struct packed {
        logic              full;
        logic              empty;
        logic [QPTR_W:0]   count;
    } t_q_status;

    // atan(2^-i) at 2^30 scale
    function automatic logic signed [ACC_W-1:0] atan_q30(input int idx);
        logic signed [ACC_W-1:0] v;
        case (idx)
            0:  v = 35'sd843314857;
            1:  v = 35'sd497837829;
            2:  v = 35'sd263043837;
            3:  v = 35'sd133525159;
            4:  v = 35'sd67021687;
            5:  v = 35'sd33543516;
            6:  v = 35'sd16775851;
            7:  v = 35'sd8388437;
            8:  v = 35'sd4194283;
            9:  v = 35'sd2097149;
            10: v = 35'sd1048576;
            11: v = 35'sd524288;
            12: v = 35'sd262144;
            13: v = 35'sd131072;
            14: v = 35'sd65536;
            15: v = 35'sd32768;
            16: v = 35'sd16384;
            17: v = 35'sd8192;
            18: v = 35'sd4096;
            19: v = 35'sd2048;
            20: v = 35'sd1024;
            21: v = 35'sd512;
            22: v = 35'sd256;
            23: v = 35'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

    // Half-turn pre-rotation when the x argument is negative
    function automatic t_lane cordic_pre(input logic signed [VEC_W-1:0] num,
                                         input logic signed [VEC_W-1:0] den);
        t_lane l;
        l.zero = (num == '0) && (den == '0);
        l.vx   = den;
        l.vy   = num;
        l.acc  = '0;
        if (den < 0) begin
            l.acc = (num >= 0) ? PI_Q30 : -PI_Q30;
            l.vx  = -den;
            l.vy  = -num;
        end
        return l;
    endfunction

    function automatic t_lane cordic_iter(input t_lane l, input int i);
        t_lane                   n;
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] dx;
        logic signed [VEC_W-1:0] dy;
        n  = l;
        vx = l.vx;
        vy = l.vy;
        dx = vy >>> i;
        dy = vx >>> i;
        if (vy > 0) begin
            n.vx  = vx + dx;
            n.vy  = vy - dy;
            n.acc = l.acc + atan_q30(i);
        end else begin
            n.vx  = vx - dx;
            n.vy  = vy + dy;
            n.acc = l.acc - atan_q30(i);
        end
        return n;
    endfunction

    // Round half up to the output scale, then saturate to a field of the given width
    function automatic logic [ROLL_W-1:0] round_angle(input t_lane l, input int frac_bits,
                                                      input int width);
        logic signed [ACC_W:0] v;
        logic signed [ACC_W:0] hi;
        logic signed [ACC_W:0] lo;
        int                    sh;
        sh = ACC_FRAC - frac_bits;
        v  = l.zero ? '0 : (ACC_W+1)'(l.acc);
        v  = v + ((ACC_W+1)'(1) << (sh - 1));
        v  = v >>> sh;
        hi = ((ACC_W+1)'(1) << (width - 1)) - (ACC_W+1)'(1);
        lo = -hi - (ACC_W+1)'(1);
        if (v > hi) v = hi;
        if (v < lo) v = lo;
        return v[ROLL_W-1:0];
    endfunction

endpackage

@@ rtl/qte_front.sv @@
// Front pipeline: takes quaternions, forms the atan2 arguments and the
// square-root operand for pitch. Depends on qte_pkg.
module qte_front
    import qte_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic signed [QUAT_W-1:0] i_quat_w,
    input  logic signed [QUAT_W-1:0] i_quat_x,
    input  logic signed [QUAT_W-1:0] i_quat_y,
    input  logic signed [QUAT_W-1:0] i_quat_z,
    input  logic                     i_q_full,
    output logic                     o_valid,
    output t_front_item              o_item
);

    logic adv;
    logic r_v1, r_v2, r_v3, r_v4, r_v5;

    logic signed [QUAT_W-1:0] r_w, r_x, r_y, r_z;
    logic signed [2*QUAT_W-1:0] r_wx, r_yz, r_xx, r_yy, r_wy, r_zx, r_wz, r_xy, r_zz;
    t_front_item r_s3, r_s4, r_s5;
    logic [ROOT_W-1:0] r_mag3;

    logic signed [PROD_W-1:0] n_p_raw;
    logic signed [PROD_W-1:0] n_p_clamp;
    logic signed [ARG_W-1:0]  n_p_arg;
    t_front_item              n_s3;
    t_front_item              n_s4;
    t_front_item              n_s5;

    assign adv = !i_q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else if (adv) begin
            r_v1 <= i_push;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
            r_v5 <= r_v4;
        end
    end

    always_comb begin
        n_p_raw = (PROD_W'(r_wy) - PROD_W'(r_zx)) <<< 1;
        if (n_p_raw > ONE_Q28) begin
            n_p_clamp = ONE_Q28;
        end else if (n_p_raw < -ONE_Q28) begin
            n_p_clamp = -ONE_Q28;
        end else begin
            n_p_clamp = n_p_raw;
        end
        n_p_arg     = ARG_W'(n_p_clamp);
        n_s3.r_num  = (PROD_W'(r_wx) + PROD_W'(r_yz)) <<< 1;
        n_s3.r_den  = ONE_Q28 - ((PROD_W'(r_xx) + PROD_W'(r_yy)) <<< 1);
        n_s3.y_num  = (PROD_W'(r_wz) + PROD_W'(r_xy)) <<< 1;
        n_s3.y_den  = ONE_Q28 - ((PROD_W'(r_yy) + PROD_W'(r_zz)) <<< 1);
        n_s3.p_arg  = n_p_arg;
        n_s3.sq_in  = '0;
        n_s4        = r_s3;
        n_s4.sq_in  = SQIN_W'(r_mag3) * SQIN_W'(r_mag3);
        n_s5        = r_s4;
        n_s5.sq_in  = ONE_Q56 - r_s4.sq_in;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_w    <= i_quat_w;
            r_x    <= i_quat_x;
            r_y    <= i_quat_y;
            r_z    <= i_quat_z;
            r_wx   <= r_w * r_x;
            r_yz   <= r_y * r_z;
            r_xx   <= r_x * r_x;
            r_yy   <= r_y * r_y;
            r_wy   <= r_w * r_y;
            r_zx   <= r_z * r_x;
            r_wz   <= r_w * r_z;
            r_xy   <= r_x * r_y;
            r_zz   <= r_z * r_z;
            r_s3   <= n_s3;
            r_mag3 <= ROOT_W'(n_p_arg < 0 ? -n_p_arg : n_p_arg);
            r_s4   <= n_s4;
            r_s5   <= n_s5;
        end
    end

    assign o_valid = r_v5 && adv;
    assign o_item  = r_s5;

endmodule

@@ rtl/qte_queue.sv @@
// Short queue between the front and back pipelines.
// Depends on qte_pkg for the item type and depth.
module qte_queue
    import qte_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_front_item i_item,
    input  logic        i_pop,
    output t_front_item o_item,
    output t_q_status   o_status
);

    t_front_item       r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wr, r_rd;
    logic [QPTR_W:0]   r_count;
    logic              do_push, do_pop;

    assign do_push = i_push && (r_count != (QPTR_W+1)'(QDEPTH));
    assign do_pop  = i_pop && (r_count != '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (do_push) r_wr <= r_wr + 1'b1;
            if (do_pop)  r_rd <= r_rd + 1'b1;
            r_count <= r_count + (QPTR_W+1)'(do_push) - (QPTR_W+1)'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wr] <= i_item;
    end

    assign o_item          = r_mem[r_rd];
    assign o_status.full   = (r_count == (QPTR_W+1)'(QDEPTH));
    assign o_status.empty  = (r_count == '0);
    assign o_status.count  = r_count;

endmodule

@@ rtl/qte_back.sv @@
// Back pipeline: integer square root for pitch, three CORDIC vectoring lanes,
// rounding and the result register. Depends on qte_pkg.
module qte_back
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_valid,
    input  t_front_item               i_item,
    input  logic                      i_pop,
    output logic                      o_q_pop,
    output logic                      o_valid,
    output logic signed [ROLL_W-1:0]  o_roll,
    output logic signed [PITCH_W-1:0] o_pitch,
    output logic signed [ROLL_W-1:0]  o_yaw
);

    typedef struct packed {
        t_front_item       item;
        logic [REM_W-1:0]  rem;
        logic [ROOT_W-1:0] root;
    } t_sq_stage;

    function automatic t_sq_stage sqrt_step(input t_sq_stage s);
        t_sq_stage        n;
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] trial;
        n     = s;
        rem   = {s.rem[REM_W-3:0], s.item.sq_in[SQIN_W-1 -: 2]};
        trial = REM_W'({s.root, 2'b01});
        if (rem >= trial) begin
            n.rem  = rem - trial;
            n.root = {s.root[ROOT_W-2:0], 1'b1};
        end else begin
            n.rem  = rem;
            n.root = {s.root[ROOT_W-2:0], 1'b0};
        end
        n.item.sq_in = s.item.sq_in << 2;
        return n;
    endfunction

    logic      adv;
    t_sq_stage r_sq   [SQRT_STEPS+1];
    logic      r_sq_v [SQRT_STEPS+1];
    t_lane     r_roll [CORDIC_STEPS+1];
    t_lane     r_pit  [CORDIC_STEPS+1];
    t_lane     r_yaw  [CORDIC_STEPS+1];
    logic      r_cv   [CORDIC_STEPS+1];
    logic      r_out_valid;
    logic [ROLL_W-1:0]  r_roll_out, r_yaw_out;
    logic [PITCH_W-1:0] r_pitch_out;
    t_sq_stage last_sq;

    // whole pipeline moves together; hold while the result waits
    assign adv     = !r_out_valid || i_pop;
    assign o_q_pop = adv && i_valid;
    assign last_sq = r_sq[SQRT_STEPS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sq_v[0] <= 1'b0;
        end else if (adv) begin
            r_sq_v[0] <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq[0].item <= i_item;
            r_sq[0].rem  <= '0;
            r_sq[0].root <= '0;
        end
    end

    for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
        t_sq_stage n_sq;
        always_comb n_sq = sqrt_step(r_sq[k]);
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_sq_v[k+1] <= 1'b0;
            end else if (adv) begin
                r_sq_v[k+1] <= r_sq_v[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) r_sq[k+1] <= n_sq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cv[0] <= 1'b0;
        end else if (adv) begin
            r_cv[0] <= r_sq_v[SQRT_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll[0] <= cordic_pre(VEC_W'(last_sq.item.r_num), VEC_W'(last_sq.item.r_den));
            r_pit[0]  <= cordic_pre(VEC_W'(last_sq.item.p_arg), VEC_W'(last_sq.root));
            r_yaw[0]  <= cordic_pre(VEC_W'(last_sq.item.y_num), VEC_W'(last_sq.item.y_den));
        end
    end

    for (genvar k = 0; k < CORDIC_STEPS; k++) begin : g_cordic
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_cv[k+1] <= 1'b0;
            end else if (adv) begin
                r_cv[k+1] <= r_cv[k];
            end
        end
        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_roll[k+1] <= cordic_iter(r_roll[k], k);
                r_pit[k+1]  <= cordic_iter(r_pit[k], k);
                r_yaw[k+1]  <= cordic_iter(r_yaw[k], k);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (adv) begin
            r_out_valid <= r_cv[CORDIC_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_roll_out  <= round_angle(r_roll[CORDIC_STEPS], ANGLE_FRAC_BITS, ROLL_W);
            r_pitch_out <= PITCH_W'(round_angle(r_pit[CORDIC_STEPS], ANGLE_FRAC_BITS,
                                                PITCH_W));
            r_yaw_out   <= round_angle(r_yaw[CORDIC_STEPS], ANGLE_FRAC_BITS, ROLL_W);
        end
    end

    assign o_valid = r_out_valid;
    assign o_roll  = r_roll_out;
    assign o_pitch = r_pitch_out;
    assign o_yaw   = r_yaw_out;

endmodule

@@ rtl/quaternion_to_euler_angles_core.sv @@
// Quaternion (Q1.14) to roll/pitch/yaw (ZYX) converter, top level.
// Depends on qte_pkg, qte_front, qte_queue and qte_back.
//
// Usage:
//   Input side is a queue write port: drive the four quaternion components
//   and raise i_push; the item is taken on a clock edge where o_full is low.
//   Result side is a queue read port: while o_empty is low the oldest result
//   sits on o_roll_angle, o_pitch_angle and o_yaw_angle; raise i_pop to take it.
//   Angles are signed radians with ANGLE_FRAC_BITS fraction bits.
// Pipeline: from the accepting edge until o_empty drops, an item passes five
//   front stages, one queue slot, 30 square-root stages for pitch,
//   CORDIC_STEPS + 1 vectoring stages and the result register, the
//   first front stage loading on the accepting edge.
// Throughput: one item per cycle unless stalled; front and back fully pipelined.
// Stalls: when i_pop is withheld the back pipeline holds as a whole; the
//   front keeps filling the four-entry middle queue and then raises o_full.
// Reset: synchronous, active low; clears all valid bits and queue pointers,
//   leaving o_empty high and o_full low.
module quaternion_to_euler_angles_core
    import qte_pkg::*;
#(
    parameter int CORDIC_STEPS    = CORDIC_STEPS_DEF,
    parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_DEF
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_push,
    output logic                      o_full,
    input  logic signed [QUAT_W-1:0]  i_quat_w,
    input  logic signed [QUAT_W-1:0]  i_quat_x,
    input  logic signed [QUAT_W-1:0]  i_quat_y,
    input  logic signed [QUAT_W-1:0]  i_quat_z,
    output logic                      o_empty,
    input  logic                      i_pop,
    output logic signed [ROLL_W-1:0]  o_roll_angle,
    output logic signed [PITCH_W-1:0] o_pitch_angle,
    output logic signed [ROLL_W-1:0]  o_yaw_angle
);

    logic        w_front_valid;
    t_front_item w_front_item;
    t_front_item w_q_item;
    t_q_status   w_q_status;
    logic        w_q_pop;
    logic        w_out_valid;

    qte_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (i_push),
        .i_quat_w (i_quat_w),
        .i_quat_x (i_quat_x),
        .i_quat_y (i_quat_y),
        .i_quat_z (i_quat_z),
        .i_q_full (w_q_status.full),
        .o_valid  (w_front_valid),
        .o_item   (w_front_item)
    );

    qte_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_front_valid),
        .i_item   (w_front_item),
        .i_pop    (w_q_pop),
        .o_item   (w_q_item),
        .o_status (w_q_status)
    );

    qte_back #(
        .CORDIC_STEPS    (CORDIC_STEPS),
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (!w_q_status.empty),
        .i_item  (w_q_item),
        .i_pop   (i_pop),
        .o_q_pop (w_q_pop),
        .o_valid (w_out_valid),
        .o_roll  (o_roll_angle),
        .o_pitch (o_pitch_angle),
        .o_yaw   (o_yaw_angle)
    );

    assign o_full  = w_q_status.full;
    assign o_empty = !w_out_valid;

    a_empty_after_reset: assert property (@(posedge i_clk)
        !$past(i_rst_n) |-> o_empty)
        else $error("result side not empty after reset");

    a_queue_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.count <= (QPTR_W+1)'(QDEPTH))
        else $error("middle queue count beyond depth");

    a_queue_pop_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_q_status.empty |-> !w_q_pop)
        else $error("back pipeline popped an empty queue");

endmodule
